FILE: src/counting_sort_by_key_assert.svh
// Assertion macros for the counting sort block.
`ifndef COUNTING_SORT_BY_KEY_ASSERT_SVH
`define COUNTING_SORT_BY_KEY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CSORT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("counting sort: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CSORT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("counting sort: next-cycle check failed");

`endif

FILE: src/csort_pkg.sv
package csort_pkg;

    localparam int MAX_KEY     = 100;
    localparam int MAX_RECORDS = 64;

    localparam int KEY_W    = 7;
    localparam int HANDLE_W = 16;
    localparam int REC_W    = KEY_W + HANDLE_W;
    localparam int TDATA_W  = ((REC_W + 7) / 8) * 8;

    localparam int KEY_AW = $clog2(MAX_KEY + 1);
    localparam int IDX_W  = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } rec_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CLR,
        IDX_INC,
        IDX_DEC,
        IDX_TOP
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_RD_NONE,
        CNT_RD_K,
        CNT_RD_KEY
    } cnt_rd_t;

    typedef enum logic [2:0] {
        CNT_WR_NONE,
        CNT_WR_ZERO,
        CNT_WR_INC,
        CNT_WR_PFX,
        CNT_WR_DEC
    } cnt_wr_t;

    typedef struct packed {
        logic    load;
        logic    batch_done;
        idx_op_t idx_op;
        logic    k_clr;
        logic    k_inc;
        logic    in_rd;
        logic    rec_hold;
        cnt_rd_t cnt_rd;
        cnt_wr_t cnt_wr;
        logic    out_wr;
        logic    out_rd;
        logic    emit_ld;
    } cmd_t;

    typedef struct packed {
        logic load_full;
        logic idx_first;
        logic idx_last;
        logic k_last;
    } status_t;

endpackage

FILE: src/counting_sort_by_key.sv
// Operation: a batch of n records loads at one word per cycle; after the closing word the
// block clears the count table, then counts keys, builds prefix sums and places records
// through read-modify-write of the count table, and emits the records in key order.
// Each sorted word is read from the output store, loaded into the output register and held
// until m_tready; no new batch is accepted until the last sorted word has been taken.
// Reset (rst_n low, asynchronous): load count cleared, loading phase, ready to take input.
module counting_sort_by_key (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [csort_pkg::TDATA_W-1:0] s_tdata,  // [6:0] sort_key, [22:7] record_handle
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [csort_pkg::TDATA_W-1:0] m_tdata,  // [6:0] sorted_key, [22:7] sorted_handle
    output logic                          m_tlast
);

    csort_pkg::cmd_t    cmd;
    csort_pkg::status_t status;

    csort_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    csort_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

`include "counting_sort_by_key_assert.svh"

    `CSORT_ASSERT_NOW(a_load_excludes_emit, s_tready, !m_tvalid)
    `CSORT_ASSERT_NEXT(a_last_closes_load, s_tvalid && s_tready && s_tlast, !s_tready)
    `CSORT_ASSERT_NEXT(a_end_reopens_load, m_tvalid && m_tready && m_tlast, s_tready)

endmodule

FILE: src/csort_ram.sv
module csort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/csort_ctrl.sv
module csort_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  csort_pkg::status_t status,
    output csort_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_COUNT_RD,
        ST_COUNT_KEY,
        ST_COUNT_WR,
        ST_PFX_RD,
        ST_PFX_WR,
        ST_PLACE_RD,
        ST_PLACE_KEY,
        ST_PLACE_WR,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb
    begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid && s_tready_reg)
                begin
                    cmd.load = 1'b1;
                    if (s_tlast || status.load_full)
                    begin
                        cmd.k_clr     = 1'b1;
                        s_tready_next = 1'b0;
                        state_next    = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.cnt_wr = csort_pkg::CNT_WR_ZERO;
                cmd.k_inc  = 1'b1;
                if (status.k_last)
                begin
                    cmd.idx_op = csort_pkg::IDX_CLR;
                    state_next = ST_COUNT_RD;
                end
            end
            ST_COUNT_RD:
            begin
                cmd.in_rd  = 1'b1;
                state_next = ST_COUNT_KEY;
            end
            ST_COUNT_KEY:
            begin
                cmd.cnt_rd   = csort_pkg::CNT_RD_KEY;
                cmd.rec_hold = 1'b1;
                state_next   = ST_COUNT_WR;
            end
            ST_COUNT_WR:
            begin
                cmd.cnt_wr = csort_pkg::CNT_WR_INC;
                if (status.idx_last)
                begin
                    cmd.k_clr  = 1'b1;
                    state_next = ST_PFX_RD;
                end
                else
                begin
                    cmd.idx_op = csort_pkg::IDX_INC;
                    state_next = ST_COUNT_RD;
                end
            end
            ST_PFX_RD:
            begin
                cmd.cnt_rd = csort_pkg::CNT_RD_K;
                state_next = ST_PFX_WR;
            end
            ST_PFX_WR:
            begin
                cmd.cnt_wr = csort_pkg::CNT_WR_PFX;
                if (status.k_last)
                begin
                    cmd.idx_op = csort_pkg::IDX_TOP;
                    state_next = ST_PLACE_RD;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_PFX_RD;
                end
            end
            ST_PLACE_RD:
            begin
                cmd.in_rd  = 1'b1;
                state_next = ST_PLACE_KEY;
            end
            ST_PLACE_KEY:
            begin
                cmd.cnt_rd   = csort_pkg::CNT_RD_KEY;
                cmd.rec_hold = 1'b1;
                state_next   = ST_PLACE_WR;
            end
            ST_PLACE_WR:
            begin
                // place the record just below its running slot and pull the slot down
                cmd.cnt_wr = csort_pkg::CNT_WR_DEC;
                cmd.out_wr = 1'b1;
                if (status.idx_first)
                begin
                    cmd.idx_op = csort_pkg::IDX_CLR;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    cmd.idx_op = csort_pkg::IDX_DEC;
                    state_next = ST_PLACE_RD;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                cmd.emit_ld   = 1'b1;
                m_tvalid_next = 1'b1;
                state_next    = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    if (status.idx_last)
                    begin
                        cmd.batch_done = 1'b1;
                        s_tready_next  = 1'b1;
                        state_next     = ST_LOAD;
                    end
                    else
                    begin
                        cmd.idx_op = csort_pkg::IDX_INC;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next    = ST_LOAD;
                s_tready_next = 1'b1;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: src/csort_dp.sv
module csort_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  csort_pkg::cmd_t                 cmd,
    input  logic [csort_pkg::TDATA_W-1:0]   s_tdata,
    output csort_pkg::status_t              status,
    output logic [csort_pkg::TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    localparam int KW  = csort_pkg::KEY_W;
    localparam int HW  = csort_pkg::HANDLE_W;
    localparam int RW  = csort_pkg::REC_W;
    localparam int DW  = csort_pkg::TDATA_W;
    localparam int KAW = csort_pkg::KEY_AW;
    localparam int IW  = csort_pkg::IDX_W;
    localparam int CW  = csort_pkg::CNT_W;

    logic [CW-1:0]   load_cnt_reg, load_cnt_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [KAW-1:0]  k_reg, k_next;
    logic [CW-1:0]   acc_reg, acc_next;
    csort_pkg::rec_t rec_reg;
    logic [DW-1:0]   m_tdata_reg;
    logic            m_tlast_reg;

    csort_pkg::rec_t in_rec;
    csort_pkg::rec_t in_rdata;
    csort_pkg::rec_t out_rdata;
    logic [KW-1:0]   key_sat;
    logic [CW-1:0]   cnt_rdata;
    logic [CW-1:0]   pfx_sum;
    logic [KAW-1:0]  cnt_rd_addr;
    logic            cnt_wr_en;
    logic [KAW-1:0]  cnt_wr_addr;
    logic [CW-1:0]   cnt_wr_data;
    logic [CW-1:0]   slot_below;

    // saturate the key on arrival
    always_comb
    begin
        if (int'(s_tdata[KW-1:0]) > csort_pkg::MAX_KEY)
        begin
            key_sat = KW'(csort_pkg::MAX_KEY);
        end
        else
        begin
            key_sat = s_tdata[KW-1:0];
        end
        in_rec.key    = key_sat;
        in_rec.handle = s_tdata[KW+HW-1:KW];
    end

    csort_ram #(
        .WIDTH (RW),
        .DEPTH (csort_pkg::MAX_RECORDS)
    ) u_in_store (
        .clk     (clk),
        .wr_en   (cmd.load),
        .wr_addr (load_cnt_reg[IW-1:0]),
        .wr_data (in_rec),
        .rd_en   (cmd.in_rd),
        .rd_addr (idx_reg),
        .rd_data (in_rdata)
    );

    assign pfx_sum    = acc_reg + cnt_rdata;
    assign slot_below = cnt_rdata - CW'(1);

    always_comb
    begin
        if (cmd.cnt_rd == csort_pkg::CNT_RD_KEY)
        begin
            cnt_rd_addr = KAW'(in_rdata.key);
        end
        else
        begin
            cnt_rd_addr = k_reg;
        end
    end

    always_comb
    begin
        cnt_wr_en   = 1'b1;
        cnt_wr_addr = k_reg;
        cnt_wr_data = '0;
        case (cmd.cnt_wr)
            csort_pkg::CNT_WR_ZERO:
            begin
                cnt_wr_addr = k_reg;
                cnt_wr_data = '0;
            end
            csort_pkg::CNT_WR_INC:
            begin
                cnt_wr_addr = KAW'(rec_reg.key);
                cnt_wr_data = cnt_rdata + CW'(1);
            end
            csort_pkg::CNT_WR_PFX:
            begin
                cnt_wr_addr = k_reg;
                cnt_wr_data = pfx_sum;
            end
            csort_pkg::CNT_WR_DEC:
            begin
                cnt_wr_addr = KAW'(rec_reg.key);
                cnt_wr_data = slot_below;
            end
            default:
            begin
                cnt_wr_en = 1'b0;
            end
        endcase
    end

    csort_ram #(
        .WIDTH (CW),
        .DEPTH (csort_pkg::MAX_KEY + 1)
    ) u_count_table (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (cmd.cnt_rd != csort_pkg::CNT_RD_NONE),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rdata)
    );

    csort_ram #(
        .WIDTH (RW),
        .DEPTH (csort_pkg::MAX_RECORDS)
    ) u_out_store (
        .clk     (clk),
        .wr_en   (cmd.out_wr),
        .wr_addr (slot_below[IW-1:0]),
        .wr_data (rec_reg),
        .rd_en   (cmd.out_rd),
        .rd_addr (idx_reg),
        .rd_data (out_rdata)
    );

    always_comb
    begin
        status.load_full = (load_cnt_reg == CW'(csort_pkg::MAX_RECORDS - 1));
        status.idx_first = (idx_reg == '0);
        status.idx_last  = ((CW'(idx_reg) + CW'(1)) == load_cnt_reg);
        status.k_last    = (k_reg == KAW'(csort_pkg::MAX_KEY));
    end

    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        if (cmd.batch_done)
        begin
            load_cnt_next = '0;
        end
        else if (cmd.load)
        begin
            load_cnt_next = load_cnt_reg + CW'(1);
        end

        idx_next = idx_reg;
        case (cmd.idx_op)
            csort_pkg::IDX_CLR:  idx_next = '0;
            csort_pkg::IDX_INC:  idx_next = idx_reg + IW'(1);
            csort_pkg::IDX_DEC:  idx_next = idx_reg - IW'(1);
            csort_pkg::IDX_TOP:  idx_next = IW'(load_cnt_reg - CW'(1));
            default:             idx_next = idx_reg;
        endcase

        k_next   = k_reg;
        acc_next = acc_reg;
        if (cmd.k_clr)
        begin
            k_next   = '0;
            acc_next = '0;
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + KAW'(1);
        end
        if (cmd.cnt_wr == csort_pkg::CNT_WR_PFX)
        begin
            acc_next = pfx_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            idx_reg      <= '0;
            k_reg        <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            idx_reg      <= idx_next;
            k_reg        <= k_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rec_hold)
        begin
            rec_reg <= in_rdata;
        end
        if (cmd.emit_ld)
        begin
            m_tdata_reg <= DW'(out_rdata);
            m_tlast_reg <= status.idx_last;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;

endmodule
